@@ sv/owms_pkg.sv @@
`timescale 1ns / 1ps

package owms_pkg;

    localparam int unsigned READ_TAIL_US_DEF = 50;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [9:0] RESET_LOW_US_RST       = 10'd480;
    localparam logic [9:0] PRESENCE_SAMPLE_US_RST = 10'd70;
    localparam logic [9:0] RESET_TAIL_US_RST      = 10'd460;
    localparam logic [7:0] WRITE_ONE_LOW_US_RST   = 8'd5;
    localparam logic [7:0] WRITE_ZERO_LOW_US_RST  = 8'd55;
    localparam logic [7:0] WRITE_SLOT_US_RST      = 8'd60;
    localparam logic [7:0] READ_LOW_US_RST        = 8'd1;
    localparam logic [7:0] READ_SAMPLE_US_RST     = 8'd10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_RESET = 2'd1,
        SEQ_WRITE = 2'd2,
        SEQ_READ  = 2'd3
    } seq_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RESET_LOW       = 4'd0,
        CFG_PRESENCE_SAMPLE = 4'd1,
        CFG_RESET_TAIL      = 4'd2,
        CFG_WRITE_ONE_LOW   = 4'd3,
        CFG_WRITE_ZERO_LOW  = 4'd4,
        CFG_WRITE_SLOT      = 4'd5,
        CFG_READ_LOW        = 4'd6,
        CFG_READ_SAMPLE     = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_sample_us;
        logic [9:0] reset_tail_us;
        logic [7:0] write_one_low_us;
        logic [7:0] write_zero_low_us;
        logic [7:0] write_slot_us;
        logic [7:0] read_low_us;
        logic [7:0] read_sample_us;
    } cfg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] write_data;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       command_ignored;
    } out_item_t;

endpackage

@@ sv/owms_cfg_regs.sv @@
`timescale 1ns / 1ps

module owms_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [owms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output owms_pkg::cfg_t                     cfg
);

    owms_pkg::cfg_t cfg_reg;
    owms_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (owms_pkg::cfg_idx_t'(cfg_index))
                owms_pkg::CFG_RESET_LOW:       cfg_next.reset_low_us       = cfg_data;
                owms_pkg::CFG_PRESENCE_SAMPLE: cfg_next.presence_sample_us = cfg_data;
                owms_pkg::CFG_RESET_TAIL:      cfg_next.reset_tail_us      = cfg_data;
                owms_pkg::CFG_WRITE_ONE_LOW:   cfg_next.write_one_low_us   = cfg_data[7:0];
                owms_pkg::CFG_WRITE_ZERO_LOW:  cfg_next.write_zero_low_us  = cfg_data[7:0];
                owms_pkg::CFG_WRITE_SLOT:      cfg_next.write_slot_us      = cfg_data[7:0];
                owms_pkg::CFG_READ_LOW:        cfg_next.read_low_us        = cfg_data[7:0];
                owms_pkg::CFG_READ_SAMPLE:     cfg_next.read_sample_us     = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us       <= owms_pkg::RESET_LOW_US_RST;
            cfg_reg.presence_sample_us <= owms_pkg::PRESENCE_SAMPLE_US_RST;
            cfg_reg.reset_tail_us      <= owms_pkg::RESET_TAIL_US_RST;
            cfg_reg.write_one_low_us   <= owms_pkg::WRITE_ONE_LOW_US_RST;
            cfg_reg.write_zero_low_us  <= owms_pkg::WRITE_ZERO_LOW_US_RST;
            cfg_reg.write_slot_us      <= owms_pkg::WRITE_SLOT_US_RST;
            cfg_reg.read_low_us        <= owms_pkg::READ_LOW_US_RST;
            cfg_reg.read_sample_us     <= owms_pkg::READ_SAMPLE_US_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/owms_slot_core.sv @@
`timescale 1ns / 1ps

module owms_slot_core #(
    parameter int unsigned READ_TAIL_US = owms_pkg::READ_TAIL_US_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  owms_pkg::in_item_t  item,
    input  owms_pkg::cfg_t      cfg,
    output owms_pkg::out_item_t res
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOW    = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_TAIL   = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    owms_pkg::seq_t      seq_reg, seq_next;
    logic [9:0]          cnt_reg, cnt_next;
    logic [3:0]          bits_reg, bits_next;
    logic [7:0]          shift_reg, shift_next;
    logic                presence_reg, presence_next;
    logic [7:0]          rbyte_reg, rbyte_next;
    owms_pkg::out_item_t res_reg, res_next;

    logic [7:0] wr_low;
    logic [7:0] wr_tail;
    logic [9:0] dur;
    logic [9:0] cnt_inc;
    logic       done;
    logic       ignored;

    assign res = res_reg;

    always_comb begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        cnt_next      = cnt_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        rbyte_next    = rbyte_reg;
        done          = 1'b0;
        ignored       = 1'b0;

        wr_low  = shift_reg[0] ? cfg.write_one_low_us : cfg.write_zero_low_us;
        wr_tail = (cfg.write_slot_us > wr_low) ? (cfg.write_slot_us - wr_low) : 8'd0;
        cnt_inc = cnt_reg + 10'd1;

        case (seq_reg)
            owms_pkg::SEQ_RESET: begin
                if (phase_reg == PH_LOW) begin
                    dur = cfg.reset_low_us;
                end else if (phase_reg == PH_SAMPLE) begin
                    dur = cfg.presence_sample_us;
                end else begin
                    dur = cfg.reset_tail_us;
                end
            end
            owms_pkg::SEQ_WRITE: begin
                dur = (phase_reg == PH_LOW) ? {2'b00, wr_low} : {2'b00, wr_tail};
            end
            default: begin
                if (phase_reg == PH_LOW) begin
                    dur = {2'b00, cfg.read_low_us};
                end else if (phase_reg == PH_SAMPLE) begin
                    dur = {2'b00, cfg.read_sample_us};
                end else begin
                    dur = {2'b00, 8'(READ_TAIL_US)};
                end
            end
        endcase

        if (item.operation == owms_pkg::OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                cnt_next = cnt_inc;
                if (cnt_inc >= dur || dur == 10'd0) begin
                    cnt_next = 10'd0;
                    unique case (phase_reg)
                        PH_LOW: begin
                            phase_next = (seq_reg == owms_pkg::SEQ_WRITE) ? PH_TAIL : PH_SAMPLE;
                        end
                        PH_SAMPLE: begin
                            if (seq_reg == owms_pkg::SEQ_RESET) begin
                                presence_next = ~item.line_level;
                            end else begin
                                shift_next = {item.line_level, shift_reg[7:1]};
                            end
                            phase_next = PH_TAIL;
                        end
                        PH_TAIL: begin
                            if (seq_reg == owms_pkg::SEQ_RESET) begin
                                phase_next = PH_IDLE;
                                seq_next   = owms_pkg::SEQ_NONE;
                                done       = 1'b1;
                            end else begin
                                if (seq_reg == owms_pkg::SEQ_WRITE) begin
                                    shift_next = {1'b0, shift_reg[7:1]};
                                end
                                bits_next = bits_reg - 4'd1;
                                if (bits_next != 4'd0) begin
                                    phase_next = PH_LOW;
                                end else begin
                                    if (seq_reg == owms_pkg::SEQ_READ) begin
                                        rbyte_next = shift_reg;
                                    end
                                    phase_next = PH_IDLE;
                                    seq_next   = owms_pkg::SEQ_NONE;
                                    done       = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            ignored = 1'b1;
        end else begin
            seq_next   = owms_pkg::seq_t'(item.operation);
            phase_next = PH_LOW;
            cnt_next   = 10'd0;
            if (item.operation == owms_pkg::OP_WRITE) begin
                shift_next = item.write_data;
                bits_next  = 4'd8;
            end else if (item.operation == owms_pkg::OP_READ) begin
                shift_next = 8'd0;
                bits_next  = 4'd8;
            end else begin
                bits_next  = 4'd0;
            end
        end

        res_next.drive_low       = (phase_next == PH_LOW);
        res_next.busy_res        = (phase_next != PH_IDLE);
        res_next.done_res        = done;
        res_next.presence        = presence_next;
        res_next.read_data       = rbyte_next;
        res_next.command_ignored = ignored;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            seq_reg      <= owms_pkg::SEQ_NONE;
            cnt_reg      <= 10'd0;
            bits_reg     <= 4'd0;
            shift_reg    <= 8'd0;
            presence_reg <= 1'b0;
            rbyte_reg    <= 8'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            cnt_reg      <= cnt_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rbyte_reg    <= rbyte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    a_idle_no_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == (seq_reg == owms_pkg::SEQ_NONE))
        else $error("phase and sequence disagree");

    a_reset_no_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == owms_pkg::SEQ_RESET) |-> (bits_reg == 4'd0))
        else $error("bit count set during reset sequence");

    a_byte_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == owms_pkg::SEQ_WRITE || seq_reg == owms_pkg::SEQ_READ)
        |-> (bits_reg != 4'd0 && bits_reg <= 4'd8))
        else $error("bit count out of range during byte sequence");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("sequence finished but engine not idle");

    a_ignore_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ignored) |=> ($stable(phase_reg) && $stable(seq_reg) && $stable(cnt_reg)))
        else $error("dropped command changed state");

endmodule

@@ sv/onewire_master_slot_engine.sv @@
`timescale 1ns / 1ps
// 1-Wire master slot engine: reset/presence, write byte, read byte.
// An accepted word is held in the input register, then its result is registered.
// Throughput: one word per cycle unless m_ready stalls; one state pass per word.
// Reset: aresetn (synchronous, active low) idles the engine, clears presence and
// read byte, and loads the default timing registers.
module onewire_master_slot_engine #(
    parameter int unsigned READ_TAIL_US = owms_pkg::READ_TAIL_US_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  owms_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output owms_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [owms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [owms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               in_valid_reg, in_valid_next;
    owms_pkg::in_item_t in_item_reg;
    logic               out_valid_reg, out_valid_next;
    logic               step;
    owms_pkg::cfg_t     cfg;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    owms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owms_slot_core #(
        .READ_TAIL_US (READ_TAIL_US)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (m_data)
    );

endmodule
